[rtl/ott_pkg.sv]
// Shared constants, types and functions of the object track table.
`default_nettype none
package ott_pkg;
  localparam int MAX_OBJECTS    = 32;
  localparam int SLOT_W         = 5;
  localparam int NUM_CLASSES    = 15;
  localparam int CLS_W          = 4;
  localparam int COORD_BITS     = 16;
  localparam int COUNT_W        = 16;
  localparam int IDENT_W        = 32;
  localparam int DIST_W         = 16;
  localparam int EVIDENCE_COUNT = 10;
  localparam int SMOOTH_MUL     = 3277;
  localparam int TALLY_AW       = SLOT_W + CLS_W;
  localparam int TALLY_DEPTH    = 1 << TALLY_AW;
  localparam int SCAN_W         = 6;
  localparam int SCAN_END       = MAX_OBJECTS + 2;

  localparam logic [1:0] REQ_OBSERVE = 2'd0;
  localparam logic [1:0] REQ_REMOVE  = 2'd1;
  localparam logic [1:0] REQ_CLEAR   = 2'd2;
  localparam logic [1:0] REQ_READ    = 2'd3;

  localparam logic [3:0] ST_MERGED   = 4'd0;
  localparam logic [3:0] ST_CREATED  = 4'd1;
  localparam logic [3:0] ST_FULL     = 4'd2;
  localparam logic [3:0] ST_BAD_CLS  = 4'd3;
  localparam logic [3:0] ST_REMOVED  = 4'd4;
  localparam logic [3:0] ST_NOTFOUND = 4'd5;
  localparam logic [3:0] ST_CLEARED  = 4'd6;
  localparam logic [3:0] ST_READ     = 4'd7;
  localparam logic [3:0] ST_EMPTY    = 4'd8;

  typedef struct packed {
    logic              load;
    logic              scan_v;
    logic [SLOT_W-1:0] scan_idx;
    logic              clr_we;
    logic [CLS_W-1:0]  clr_cls;
    logic              commit;
    logic [3:0]        op;
  } cmd_t;

  typedef struct packed {
    logic found;
    logic free_found;
    logic rm_found;
    logic read_valid;
    logic out_free;
  } stat_t;

  function automatic logic [2:0] group_of(input logic [CLS_W-1:0] c);
    logic [2:0] g;
    case (c)
      4'd0, 4'd1:        g = 3'd1;
      4'd2, 4'd3, 4'd4:  g = 3'd2;
      4'd5, 4'd6:        g = 3'd3;
      4'd7, 4'd8, 4'd9:  g = 3'd4;
      4'd10, 4'd11:      g = 3'd5;
      4'd12, 4'd13:      g = 3'd6;
      default:           g = 3'd0;
    endcase
    return g;
  endfunction
endpackage
`default_nettype wire

[rtl/ott_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ott_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[rtl/ott_ctrl.sv]
// Request sequencer: scan, tally read, tally clear and commit steps.
`default_nettype none
module ott_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  req_type,
  input  wire logic [ott_pkg::CLS_W-1:0]   class_in,
  input  wire ott_pkg::stat_t              stat,
  output ott_pkg::cmd_t                    cmd
);
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_MRD    = 3'd2;
  localparam logic [2:0] S_CLR    = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd4;

  logic [2:0]                   state, state_next;
  logic [ott_pkg::SCAN_W-1:0]   cnt, cnt_next;
  logic [1:0]                   req_q;
  logic                         bad_q;
  logic                         accept;
  logic                         bad_in;
  logic [3:0]                   op;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign bad_in   = (class_in >= 4'(ott_pkg::NUM_CLASSES));

  always_comb begin
    case (req_q)
      ott_pkg::REQ_OBSERVE: begin
        if (bad_q) op = ott_pkg::ST_BAD_CLS;
        else if (stat.found) op = ott_pkg::ST_MERGED;
        else if (stat.free_found) op = ott_pkg::ST_CREATED;
        else op = ott_pkg::ST_FULL;
      end
      ott_pkg::REQ_REMOVE: op = stat.rm_found ? ott_pkg::ST_REMOVED : ott_pkg::ST_NOTFOUND;
      ott_pkg::REQ_CLEAR:  op = ott_pkg::ST_CLEARED;
      default:             op = stat.read_valid ? ott_pkg::ST_READ : ott_pkg::ST_EMPTY;
    endcase
  end

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    cmd          = '0;
    cmd.op       = op;
    cmd.scan_idx = cnt[ott_pkg::SLOT_W-1:0];
    cmd.clr_cls  = cnt[ott_pkg::CLS_W-1:0];
    case (state)
      S_IDLE: begin
        cmd.load = accept;
        cnt_next = '0;
        if (accept) begin
          if ((req_type == ott_pkg::REQ_OBSERVE && !bad_in) ||
              req_type == ott_pkg::REQ_REMOVE) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_COMMIT;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_v = (cnt < 6'(ott_pkg::MAX_OBJECTS));
        cnt_next   = cnt + 6'd1;
        if (cnt == 6'(ott_pkg::SCAN_END)) begin
          cnt_next = '0;
          if (req_q == ott_pkg::REQ_REMOVE) state_next = S_COMMIT;
          else if (stat.found) state_next = S_MRD;
          else if (stat.free_found) state_next = S_CLR;
          else state_next = S_COMMIT;
        end
      end
      S_MRD: begin
        state_next = S_COMMIT;
      end
      S_CLR: begin
        cmd.clr_we = 1'b1;
        cnt_next   = cnt + 6'd1;
        if (cnt == 6'(ott_pkg::NUM_CLASSES - 1)) begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.commit = stat.out_free;
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      req_q <= ott_pkg::REQ_OBSERVE;
      bad_q <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (accept) begin
        req_q <= req_type;
        bad_q <= bad_in;
      end
    end
  end

`ifndef SYNTHESIS
  a_commit_state: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> state == S_COMMIT && stat.out_free)
    else $error("commit outside commit state");
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> cnt <= 6'(ott_pkg::SCAN_END))
    else $error("scan counter overrun");
  a_clr_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.clr_we |-> stat.free_found && !stat.found)
    else $error("tally clear without free slot");
`endif
endmodule
`default_nettype wire

[rtl/ott_dp.sv]
// Entry storage, distance scan pipeline, merge arithmetic and result register.
`default_nettype none
module ott_dp (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire ott_pkg::cmd_t                       cmd,
  output ott_pkg::stat_t                           stat,
  input  wire logic                                cfg_we,
  input  wire logic                                cfg_index,
  input  wire logic [ott_pkg::DIST_W-1:0]          cfg_data,
  input  wire logic signed [ott_pkg::COORD_BITS-1:0] pos_x,
  input  wire logic signed [ott_pkg::COORD_BITS-1:0] pos_y,
  input  wire logic [ott_pkg::CLS_W-1:0]           class_in,
  input  wire logic [ott_pkg::IDENT_W-1:0]         target_id,
  input  wire logic [ott_pkg::SLOT_W-1:0]          slot_in,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [3:0]                               status,
  output logic [ott_pkg::SLOT_W-1:0]               slot_out,
  output logic [ott_pkg::IDENT_W-1:0]              entry_id,
  output logic signed [ott_pkg::COORD_BITS-1:0]    out_x,
  output logic signed [ott_pkg::COORD_BITS-1:0]    out_y,
  output logic [ott_pkg::CLS_W-1:0]                class_out,
  output logic [ott_pkg::COUNT_W-1:0]              obs_out,
  output logic                                     evidence
);
  localparam int CW = ott_pkg::COORD_BITS;
  localparam int NW = ott_pkg::COUNT_W;
  localparam int IW = ott_pkg::IDENT_W;
  localparam int SW = ott_pkg::SLOT_W;
  localparam int KW = ott_pkg::CLS_W;
  localparam int DW = ott_pkg::DIST_W;
  localparam int MO = ott_pkg::MAX_OBJECTS;

  logic [DW-1:0]   class_dist, any_dist;
  logic [2*DW-1:0] tc_sq, ta_sq;

  logic              ent_valid [MO];
  logic signed [CW-1:0] ent_x [MO];
  logic signed [CW-1:0] ent_y [MO];
  logic [KW-1:0]     ent_cls   [MO];
  logic [NW-1:0]     ent_best  [MO];
  logic [NW-1:0]     ent_obs   [MO];
  logic              ent_evd   [MO];
  logic [IW-1:0]     ent_ident [MO];
  logic [IW-1:0]     next_ident;

  logic signed [CW-1:0] px_q, py_q;
  logic [KW-1:0]     cls_q;
  logic [IW-1:0]     tgt_q;
  logic [SW-1:0]     slot_q;

  // scan pipeline
  logic signed [CW:0] dx0, dy0;
  logic            p1_v, p1_valid, p1_grp, p1_ideq;
  logic [SW-1:0]   p1_idx;
  logic [CW:0]     p1_ax, p1_ay;
  logic [IW-1:0]   p1_ident;
  logic            p2_v, p2_valid, p2_grp, p2_ideq, p2_far;
  logic [SW-1:0]   p2_idx;
  logic [2*CW-1:0] p2_sx, p2_sy;
  logic [IW-1:0]   p2_ident;
  logic [2*CW:0]   d2;
  logic            near;

  logic            found, free_found, rm_found;
  logic [SW-1:0]   best_slot, free_slot, rm_slot;
  logic [IW-1:0]   best_id;

  logic            t_we;
  logic [ott_pkg::TALLY_AW-1:0] t_waddr, t_raddr;
  logic [NW-1:0]   t_wdata, t_rdata;

  // merge arithmetic
  logic signed [CW:0]   del_x, del_y;
  logic signed [CW+15:0] prod_x, prod_y;
  logic signed [CW-1:0] mx, my;
  logic [NW-1:0]   t_new, obs_new, best_new;
  logic [KW-1:0]   cls_new;
  logic            ev_new;
  logic [SW-1:0]   ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      class_dist <= DW'(205);
      any_dist   <= DW'(31);
    end else if (cfg_we) begin
      if (cfg_index) any_dist <= cfg_data;
      else class_dist <= cfg_data;
    end
    tc_sq <= class_dist * class_dist;
    ta_sq <= any_dist * any_dist;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px_q   <= pos_x;
      py_q   <= pos_y;
      cls_q  <= class_in;
      tgt_q  <= target_id;
      slot_q <= slot_in;
    end
  end

  assign dx0 = {ent_x[cmd.scan_idx][CW-1], ent_x[cmd.scan_idx]} - {px_q[CW-1], px_q};
  assign dy0 = {ent_y[cmd.scan_idx][CW-1], ent_y[cmd.scan_idx]} - {py_q[CW-1], py_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0;
      p2_v <= 1'b0;
    end else begin
      p1_v <= cmd.scan_v;
      p2_v <= p1_v;
    end
    p1_idx   <= cmd.scan_idx;
    p1_valid <= ent_valid[cmd.scan_idx];
    p1_ax    <= dx0[CW] ? (CW+1)'(-dx0) : (CW+1)'(dx0);
    p1_ay    <= dy0[CW] ? (CW+1)'(-dy0) : (CW+1)'(dy0);
    p1_ident <= ent_ident[cmd.scan_idx];
    p1_ideq  <= (ent_ident[cmd.scan_idx] == tgt_q);
    p1_grp   <= (ott_pkg::group_of(ent_cls[cmd.scan_idx]) != 3'd0) &&
                (ott_pkg::group_of(ent_cls[cmd.scan_idx]) == ott_pkg::group_of(cls_q));
    p2_idx   <= p1_idx;
    p2_valid <= p1_valid;
    p2_ident <= p1_ident;
    p2_ideq  <= p1_ideq;
    p2_grp   <= p1_grp;
    p2_far   <= p1_ax[CW] | p1_ay[CW];
    p2_sx    <= p1_ax[CW-1:0] * p1_ax[CW-1:0];
    p2_sy    <= p1_ay[CW-1:0] * p1_ay[CW-1:0];
  end

  assign d2   = {1'b0, p2_sx} + {1'b0, p2_sy};
  assign near = p2_valid && !p2_far &&
                (d2 < {1'b0, ta_sq} || (p2_grp && d2 < {1'b0, tc_sq}));

  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      found      <= 1'b0;
      free_found <= 1'b0;
      rm_found   <= 1'b0;
    end else if (p2_v) begin
      if (near && (!found || p2_ident < best_id)) begin
        found <= 1'b1;
      end
      if (!p2_valid && !free_found) free_found <= 1'b1;
      if (p2_valid && p2_ideq && !rm_found) rm_found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (p2_v) begin
      if (near && (!found || p2_ident < best_id)) begin
        best_slot <= p2_idx;
        best_id   <= p2_ident;
      end
      if (!p2_valid && !free_found) free_slot <= p2_idx;
      if (p2_valid && p2_ideq && !rm_found) rm_slot <= p2_idx;
    end
  end

  assign t_raddr = {best_slot, cls_q};
  assign t_we    = cmd.clr_we || (cmd.commit && cmd.op == ott_pkg::ST_MERGED);
  assign t_waddr = cmd.clr_we ? {free_slot, cmd.clr_cls} : {best_slot, cls_q};
  assign t_wdata = cmd.clr_we ? ((cmd.clr_cls == cls_q) ? NW'(1) : NW'(0)) : t_new;

  ott_ram #(.WIDTH(NW), .DEPTH(ott_pkg::TALLY_DEPTH)) u_tally (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  assign ms     = best_slot;
  assign del_x  = {px_q[CW-1], px_q} - {ent_x[ms][CW-1], ent_x[ms]};
  assign del_y  = {py_q[CW-1], py_q} - {ent_y[ms][CW-1], ent_y[ms]};
  assign prod_x = del_x * $signed(16'(ott_pkg::SMOOTH_MUL));
  assign prod_y = del_y * $signed(16'(ott_pkg::SMOOTH_MUL));
  assign mx     = CW'(ent_x[ms] + CW'(prod_x >>> 16));
  assign my     = CW'(ent_y[ms] + CW'(prod_y >>> 16));
  assign t_new  = (t_rdata == '1) ? t_rdata : t_rdata + NW'(1);
  assign obs_new = (ent_obs[ms] == '1) ? ent_obs[ms] : ent_obs[ms] + NW'(1);
  assign ev_new = (obs_new >= NW'(ott_pkg::EVIDENCE_COUNT)) && !ent_evd[ms];

  always_comb begin
    cls_new  = ent_cls[ms];
    best_new = ent_best[ms];
    if (cls_q == ent_cls[ms]) begin
      best_new = t_new;
    end else if (t_new > ent_best[ms] || (t_new == ent_best[ms] && cls_q < ent_cls[ms])) begin
      cls_new  = cls_q;
      best_new = t_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MO; i++) ent_valid[i] <= 1'b0;
      next_ident <= '0;
    end else if (cmd.commit) begin
      case (cmd.op)
        ott_pkg::ST_CREATED: begin
          ent_valid[free_slot] <= 1'b1;
          next_ident <= next_ident + IW'(1);
        end
        ott_pkg::ST_REMOVED: ent_valid[rm_slot] <= 1'b0;
        ott_pkg::ST_CLEARED: for (int i = 0; i < MO; i++) ent_valid[i] <= 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      case (cmd.op)
        ott_pkg::ST_MERGED: begin
          ent_x[ms]    <= mx;
          ent_y[ms]    <= my;
          ent_cls[ms]  <= cls_new;
          ent_best[ms] <= best_new;
          ent_obs[ms]  <= obs_new;
          if (ev_new) ent_evd[ms] <= 1'b1;
        end
        ott_pkg::ST_CREATED: begin
          ent_x[free_slot]     <= px_q;
          ent_y[free_slot]     <= py_q;
          ent_cls[free_slot]   <= cls_q;
          ent_best[free_slot]  <= NW'(1);
          ent_obs[free_slot]   <= NW'(1);
          ent_evd[free_slot]   <= 1'b0;
          ent_ident[free_slot] <= next_ident;
        end
        default: ;
      endcase
    end
  end

  assign stat.found      = found;
  assign stat.free_found = free_found;
  assign stat.rm_found   = rm_found;
  assign stat.read_valid = ent_valid[slot_q];
  assign stat.out_free   = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status    <= cmd.op;
      slot_out  <= '0;
      entry_id  <= '0;
      out_x     <= '0;
      out_y     <= '0;
      class_out <= '0;
      obs_out   <= '0;
      evidence  <= 1'b0;
      case (cmd.op)
        ott_pkg::ST_MERGED: begin
          slot_out  <= ms;
          entry_id  <= ent_ident[ms];
          out_x     <= mx;
          out_y     <= my;
          class_out <= cls_new;
          obs_out   <= obs_new;
          evidence  <= ev_new;
        end
        ott_pkg::ST_CREATED: begin
          slot_out  <= free_slot;
          entry_id  <= next_ident;
          out_x     <= px_q;
          out_y     <= py_q;
          class_out <= cls_q;
          obs_out   <= NW'(1);
        end
        ott_pkg::ST_REMOVED: begin
          slot_out  <= rm_slot;
          entry_id  <= ent_ident[rm_slot];
          out_x     <= ent_x[rm_slot];
          out_y     <= ent_y[rm_slot];
          class_out <= ent_cls[rm_slot];
          obs_out   <= ent_obs[rm_slot];
        end
        ott_pkg::ST_READ: begin
          slot_out  <= slot_q;
          entry_id  <= ent_ident[slot_q];
          out_x     <= ent_x[slot_q];
          out_y     <= ent_y[slot_q];
          class_out <= ent_cls[slot_q];
          obs_out   <= ent_obs[slot_q];
        end
        ott_pkg::ST_EMPTY: slot_out <= slot_q;
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("result not presented after commit");
  a_evd_merge: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && cmd.op != ott_pkg::ST_MERGED |=> !evidence)
    else $error("evidence outside merge");
  a_ident_step: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && cmd.op == ott_pkg::ST_CREATED |=> next_ident == $past(next_ident) + IW'(1))
    else $error("identity not advanced on create");
`endif
endmodule
`default_nettype wire

[rtl/object_track_table.sv]
// Top level of the object track table: sequencer, datapath and tally memory.
//   channel   direction  handshake            payload
//   request   in         in_valid / in_stall  req_type pos_x pos_y class_in target_id slot_in
//   result    out        out_valid/out_stall  status slot_out entry_id out_x out_y class_out
//                                             obs_out evidence
//   config    in         cfg_we               cfg_index cfg_data
// Observe and remove: accept, a scan of the 32 slots through the distance pipe, then commit
// for a remove or a full table, a tally read then commit for a merge, or a 15-entry tally
// sweep then commit for a create.
// Clear, read and rejected observations go from accept straight to commit.
// One item is in work at a time; commit holds while a stalled result fills the output.
// Reset is synchronous, clears slot valid bits and the identity counter, and loads default thresholds.
`default_nettype none
module object_track_table (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic [1:0]                            req_type,
  input  wire logic signed [ott_pkg::COORD_BITS-1:0] pos_x,
  input  wire logic signed [ott_pkg::COORD_BITS-1:0] pos_y,
  input  wire logic [ott_pkg::CLS_W-1:0]             class_in,
  input  wire logic [ott_pkg::IDENT_W-1:0]           target_id,
  input  wire logic [ott_pkg::SLOT_W-1:0]            slot_in,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic [3:0]                                 status,
  output logic [ott_pkg::SLOT_W-1:0]                 slot_out,
  output logic [ott_pkg::IDENT_W-1:0]                entry_id,
  output logic signed [ott_pkg::COORD_BITS-1:0]      out_x,
  output logic signed [ott_pkg::COORD_BITS-1:0]      out_y,
  output logic [ott_pkg::CLS_W-1:0]                  class_out,
  output logic [ott_pkg::COUNT_W-1:0]                obs_out,
  output logic                                       evidence,
  input  wire logic                                  cfg_we,
  input  wire logic                                  cfg_index,
  input  wire logic [ott_pkg::DIST_W-1:0]            cfg_data
);
  ott_pkg::cmd_t  cmd;
  ott_pkg::stat_t stat;

  ott_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .req_type (req_type),
    .class_in (class_in),
    .stat     (stat),
    .cmd      (cmd)
  );

  ott_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .class_in  (class_in),
    .target_id (target_id),
    .slot_in   (slot_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .slot_out  (slot_out),
    .entry_id  (entry_id),
    .out_x     (out_x),
    .out_y     (out_y),
    .class_out (class_out),
    .obs_out   (obs_out),
    .evidence  (evidence)
  );
endmodule
`default_nettype wire
